/* rtl/efw_pkg.sv */
// Shared constants, types and constant functions for the exposure-fusion weight block.
// No dependencies; used by every module under rtl/.
package efw_pkg;

  // 27 * 255^2, scale of the channel deviation sum
  localparam logic [20:0] SAT_K     = 21'd1755675;
  localparam int          SAT_BITS  = 15;
  // log2(e) in Q.16 and 2 * 255^2
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [16:0] SIG_SCALE = 17'd130050;

  localparam int G_BITS     = 25;
  localparam int N_BITS     = 30;
  localparam int NL_BITS    = 21;
  localparam int FRAC_STEPS = 16;

  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam logic [31:0] TWO_Q30    = 32'h8000_0000;
  localparam logic [13:0] EXP_ZERO_Q = 14'd17;

  // alignment delays between the parallel branches
  localparam int CON_DLY    = 15;
  localparam int G_DLY      = 7;
  localparam int ZERO_DLY   = 18;
  localparam int EXPO_DLY   = 9;
  localparam int SAT_DLY    = 38;
  localparam int PIPE_DEPTH = 57;

  typedef enum logic [2:0] {
    CFG_EXPO_MEAN  = 3'd0,
    CFG_EXPO_SIGMA = 3'd1,
    CFG_SAT_EXP    = 3'd2,
    CFG_CON_EXP    = 3'd3,
    CFG_EXPO_EXP   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] weight;
    logic [15:0] saturation;
    logic [15:0] exposedness;
  } result_t;

  typedef logic [31:0] root_tab_t [FRAC_STEPS];

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] pw;
    v  = val;
    r  = '0;
    pw = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + pw) begin
        v = v - (r + pw);
        r = (r >> 1) + pw;
      end else begin
        r = r >> 1;
      end
      pw = pw >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q2.30, k = 1..16, each from the truncated previous root
  function automatic root_tab_t root_table();
    root_tab_t   tab;
    logic [63:0] c;
    c = isqrt64(64'd1 << 61);
    for (int k = 0; k < FRAC_STEPS; k++) begin
      tab[k] = c[31:0];
      c = isqrt64(c << 30);
    end
    return tab;
  endfunction

  localparam root_tab_t ROOT_TAB = root_table();

endpackage

/* rtl/efw_front.sv */
// Front stages: channel deviations, squares, sums and the scaled exposure numerator.
// Depends on efw_pkg. Four register stages, all advanced by en.
module efw_front (
  input  logic        clk,
  input  logic        en,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [15:0] contrast,
  input  logic [7:0]  expo_mean,
  output logic [18:0] dsum,
  output logic [50:0] num,
  output logic [15:0] con
);

  logic [7:0]  ch [3];
  logic [9:0]  sum3;
  logic [15:0] am;
  logic [8:0]  ds_c [3];
  logic [15:0] de_c [3];

  logic [8:0]  ds_q  [3];
  logic [15:0] de_q  [3];
  logic [17:0] dss_q [3];
  logic [31:0] des_q [3];
  logic [18:0] dsum3;
  logic [33:0] d2sum;
  logic [15:0] con1, con2, con3;

  assign ch[0] = red;
  assign ch[1] = green;
  assign ch[2] = blue;
  assign sum3  = {2'd0, red} + {2'd0, green} + {2'd0, blue};
  assign am    = {expo_mean, 8'd0} - {8'd0, expo_mean};

  always_comb begin
    logic [9:0]  tx;
    logic [9:0]  dv;
    logic [15:0] ad;
    for (int i = 0; i < 3; i++) begin
      tx = {1'b0, ch[i], 1'b0} + {2'd0, ch[i]};
      dv = (tx >= sum3) ? (tx - sum3) : (sum3 - tx);
      ds_c[i] = dv[8:0];
      ad = {ch[i], 8'd0};
      de_c[i] = (ad >= am) ? (ad - am) : (am - ad);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ds_q[i]  <= ds_c[i];
        de_q[i]  <= de_c[i];
        dss_q[i] <= {9'd0, ds_q[i]} * {9'd0, ds_q[i]};
        des_q[i] <= {16'd0, de_q[i]} * {16'd0, de_q[i]};
      end
      con1  <= contrast;
      con2  <= con1;
      dsum3 <= {1'b0, dss_q[0]} + {1'b0, dss_q[1]} + {1'b0, dss_q[2]};
      d2sum <= {2'd0, des_q[0]} + {2'd0, des_q[1]} + {2'd0, des_q[2]};
      con3  <= con2;
      dsum  <= dsum3;
      num   <= {17'd0, d2sum} * {34'd0, efw_pkg::LOG2E_Q16};
      con   <= con3;
    end
  end

endmodule

/* rtl/efw_sqrt.sv */
// Saturation root: largest s with s^2 * K <= D * 2^32, one result bit per stage.
// Depends on efw_pkg.
module efw_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [18:0] dsum,
  output logic [14:0] sat
);

  logic [50:0] rem_q  [efw_pkg::SAT_BITS];
  logic [36:0] acc_q  [efw_pkg::SAT_BITS];
  logic [14:0] root_q [efw_pkg::SAT_BITS];

  for (genvar j = 0; j < efw_pkg::SAT_BITS; j++) begin : g_step
    localparam int B = efw_pkg::SAT_BITS - 1 - j;
    logic [50:0] rem_in;
    logic [36:0] acc_in;
    logic [14:0] root_in;
    logic [52:0] trial;

    if (j == 0) begin : g_first
      assign rem_in  = {dsum, 32'd0};
      assign acc_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign acc_in  = acc_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial = ({16'd0, acc_in} << (B + 1)) + ({32'd0, efw_pkg::SAT_K} << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'd0, rem_in} >= trial) begin
          rem_q[j]  <= rem_in - trial[50:0];
          acc_q[j]  <= acc_in + ({16'd0, efw_pkg::SAT_K} << B);
          root_q[j] <= root_in | (15'd1 << B);
        end else begin
          rem_q[j]  <= rem_in;
          acc_q[j]  <= acc_in;
          root_q[j] <= root_in;
        end
      end
    end
  end

  assign sat = root_q[efw_pkg::SAT_BITS-1];

endmodule

/* rtl/efw_div.sv */
// Restoring divider for -log2 of exposedness, quotient clamped to G_BITS.
// Depends on efw_pkg. One overflow stage, then one quotient bit per stage.
module efw_div (
  input  logic        clk,
  input  logic        en,
  input  logic [50:0] num,
  input  logic [32:0] divisor,
  output logic [24:0] g
);

  logic [50:0] rem0;
  logic        ovf0;
  logic [50:0] rem_q [efw_pkg::G_BITS];
  logic [24:0] quo_q [efw_pkg::G_BITS];
  logic        ovf_q [efw_pkg::G_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= num;
      ovf0 <= {7'd0, num} >= {divisor, 25'd0};
    end
  end

  for (genvar j = 0; j < efw_pkg::G_BITS; j++) begin : g_step
    localparam int B = efw_pkg::G_BITS - 1 - j;
    logic [50:0] rem_in;
    logic [24:0] quo_in;
    logic        ovf_in;
    logic [57:0] sh;

    if (j == 0) begin : g_first
      assign rem_in = rem0;
      assign quo_in = '0;
      assign ovf_in = ovf0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign quo_in = quo_q[j-1];
      assign ovf_in = ovf_q[j-1];
    end

    assign sh = {25'd0, divisor} << B;

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_q[j] <= ovf_in;
        if ({7'd0, rem_in} >= sh) begin
          rem_q[j] <= rem_in - sh[50:0];
          quo_q[j] <= quo_in | (25'd1 << B);
        end else begin
          rem_q[j] <= rem_in;
          quo_q[j] <= quo_in;
        end
      end
    end
  end

  assign g = ovf_q[efw_pkg::G_BITS-1] ? '1 : quo_q[efw_pkg::G_BITS-1];

endmodule

/* rtl/efw_nlog.sv */
// Fixed-point -log2(u/65536) in Q.16 by repeated squaring of a Q1.30 mantissa.
// Depends on efw_pkg. Normalize stage, one squaring per stage, final subtract.
module efw_nlog (
  input  logic        clk,
  input  logic        en,
  input  logic [15:0] u,
  output logic [20:0] nl
);

  logic [15:0] u0;
  logic [3:0]  p_c;
  logic [30:0] m_init;

  logic [30:0] m0;
  logic [3:0]  p0;
  logic [30:0] m_q    [efw_pkg::FRAC_STEPS];
  logic [15:0] frac_q [efw_pkg::FRAC_STEPS];
  logic [3:0]  p_q    [efw_pkg::FRAC_STEPS];

  assign u0 = (u == 16'd0) ? 16'd1 : u;

  always_comb begin
    p_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (u0[i]) p_c = 4'(i);
    end
  end

  assign m_init = {15'd0, u0} << (5'd30 - {1'b0, p_c});

  always_ff @(posedge clk) begin
    if (en) begin
      m0 <= m_init;
      p0 <= p_c;
    end
  end

  for (genvar k = 0; k < efw_pkg::FRAC_STEPS; k++) begin : g_step
    logic [30:0] m_in;
    logic [15:0] f_in;
    logic [3:0]  p_in;
    logic [61:0] sq;
    logic [31:0] hi;

    if (k == 0) begin : g_first
      assign m_in = m0;
      assign f_in = '0;
      assign p_in = p0;
    end else begin : g_next
      assign m_in = m_q[k-1];
      assign f_in = frac_q[k-1];
      assign p_in = p_q[k-1];
    end

    assign sq = {31'd0, m_in} * {31'd0, m_in};
    assign hi = sq[61:30];

    always_ff @(posedge clk) begin
      if (en) begin
        m_q[k]    <= hi[31] ? hi[31:1] : hi[30:0];
        frac_q[k] <= {f_in[14:0], hi[31]};
        p_q[k]    <= p_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nl <= {5'd16 - {1'b0, p_q[efw_pkg::FRAC_STEPS-1]}, 16'd0}
            - {5'd0, frac_q[efw_pkg::FRAC_STEPS-1]};
    end
  end

endmodule

/* rtl/efw_exp2.sv */
// Fixed-point 2^(-n/65536) in Q0.16 from a product of root factors, rounded, saturated.
// Depends on efw_pkg (ROOT_TAB). Split stage, one factor per stage, shift stage.
module efw_exp2 (
  input  logic        clk,
  input  logic        en,
  input  logic [29:0] n,
  output logic [15:0] res
);

  logic [16:0] hfull;
  logic [13:0] q0;
  logic [15:0] h0;
  logic        fz0;

  logic [31:0] r_q  [efw_pkg::FRAC_STEPS];
  logic [13:0] q_q  [efw_pkg::FRAC_STEPS];
  logic [15:0] h_q  [efw_pkg::FRAC_STEPS];
  logic        fz_q [efw_pkg::FRAC_STEPS];

  logic [31:0] rr;
  logic [13:0] ql;
  logic [5:0]  sh;
  logic [33:0] rsum;
  logic [33:0] rsh;
  logic [15:0] res_c;

  assign hfull = 17'h10000 - {1'b0, n[15:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      q0  <= n[29:16];
      h0  <= hfull[15:0];
      fz0 <= (n[15:0] == 16'd0);
    end
  end

  for (genvar k = 0; k < efw_pkg::FRAC_STEPS; k++) begin : g_step
    logic [31:0] r_in;
    logic [13:0] q_in;
    logic [15:0] h_in;
    logic        fz_in;
    logic [63:0] prod;

    if (k == 0) begin : g_first
      assign r_in  = efw_pkg::ONE_Q30;
      assign q_in  = q0;
      assign h_in  = h0;
      assign fz_in = fz0;
    end else begin : g_next
      assign r_in  = r_q[k-1];
      assign q_in  = q_q[k-1];
      assign h_in  = h_q[k-1];
      assign fz_in = fz_q[k-1];
    end

    assign prod = {32'd0, r_in} * {32'd0, efw_pkg::ROOT_TAB[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[k]  <= h_in[efw_pkg::FRAC_STEPS-1-k] ? prod[61:30] : r_in;
        q_q[k]  <= q_in;
        h_q[k]  <= h_in;
        fz_q[k] <= fz_in;
      end
    end
  end

  assign rr   = fz_q[efw_pkg::FRAC_STEPS-1] ? efw_pkg::TWO_Q30 : r_q[efw_pkg::FRAC_STEPS-1];
  assign ql   = q_q[efw_pkg::FRAC_STEPS-1];
  assign sh   = {1'b0, ql[4:0]} + 6'd15;
  assign rsum = {2'd0, rr} + (34'd1 << (sh - 6'd1));
  assign rsh  = rsum >> sh;

  always_comb begin
    if (ql > efw_pkg::EXP_ZERO_Q) begin
      res_c = 16'd0;
    end else if (rsh > 34'd65535) begin
      res_c = 16'hFFFF;
    end else begin
      res_c = rsh[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_c;
    end
  end

endmodule

/* rtl/exposure_fusion_pixel_weight_top.sv */
// Exposure-fusion pixel weight: top level, configuration, branch alignment, output buffer.
// Depends on efw_pkg, efw_front, efw_sqrt, efw_div, efw_nlog, efw_exp2.
//
//   channel  signals                                   dir  handshake
//   in       red green blue contrast                   in   in_valid / in_ready
//   out      weight saturation exposedness             out  out_valid / out_ready
//   cfg      cfg_index cfg_data                        in   cfg_wr_en, no wait
//
// One pixel per cycle while the pipeline is not held; a beat passes through the front end,
// the saturation root, one log2 unit, the exponent registers and the weight exp2 unit.
// Reset clears the configuration to defaults, the valid bits and the output buffer.
// A two-beat output buffer lets input beats continue while results wait; the pipeline
// holds only when its last stage is full and the buffer is full.
module exposure_fusion_pixel_weight_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [15:0] contrast,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] weight,
  output logic [15:0] saturation,
  output logic [15:0] exposedness,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0]  expo_mean;
  logic [7:0]  expo_sigma;
  logic [7:0]  saturation_exponent;
  logic [7:0]  contrast_exponent;
  logic [7:0]  exposure_exponent;

  logic [7:0]  sig_eff;
  logic [15:0] sig_sq;
  logic [32:0] divisor;

  logic        adv;
  logic [efw_pkg::PIPE_DEPTH-1:0] vld;

  logic [18:0] dsum;
  logic [50:0] num;
  logic [15:0] con_f;
  logic [14:0] sat;
  logic [24:0] g;
  logic [20:0] nl_s;
  logic [20:0] nl_c;
  logic [15:0] expo_raw;
  logic [15:0] wgt_raw;
  logic        zero_in;

  logic [15:0] con_d  [efw_pkg::CON_DLY];
  logic [24:0] g_d    [efw_pkg::G_DLY];
  logic        zero_d [efw_pkg::ZERO_DLY];
  logic [15:0] expo_d [efw_pkg::EXPO_DLY];
  logic [14:0] sat_d  [efw_pkg::SAT_DLY];

  logic [28:0] ps, pc;
  logic [32:0] pg;
  logic        zero1;
  logic [33:0] total;
  logic [29:0] n_w;

  efw_pkg::result_t res_new;
  efw_pkg::result_t buf0, buf1;
  logic [1:0] cnt, cnt_next;
  logic       push, pop;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      expo_mean           <= 8'd128;
      expo_sigma          <= 8'd51;
      saturation_exponent <= 8'd16;
      contrast_exponent   <= 8'd16;
      exposure_exponent   <= 8'd16;
    end else if (cfg_wr_en) begin
      unique case (efw_pkg::cfg_reg_t'(cfg_index))
        efw_pkg::CFG_EXPO_MEAN:  expo_mean           <= cfg_data;
        efw_pkg::CFG_EXPO_SIGMA: expo_sigma          <= cfg_data;
        efw_pkg::CFG_SAT_EXP:    saturation_exponent <= cfg_data;
        efw_pkg::CFG_CON_EXP:    contrast_exponent   <= cfg_data;
        efw_pkg::CFG_EXPO_EXP:   exposure_exponent   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sig_eff = (expo_sigma == 8'd0) ? 8'd1 : expo_sigma;

  always_ff @(posedge clk) begin
    sig_sq  <= {8'd0, sig_eff} * {8'd0, sig_eff};
    divisor <= {17'd0, sig_sq} * {16'd0, efw_pkg::SIG_SCALE};
  end

  // pipeline control
  assign adv      = !vld[efw_pkg::PIPE_DEPTH-1] || (cnt != 2'd2);
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[efw_pkg::PIPE_DEPTH-2:0], in_valid};
    end
  end

  efw_front u_front (
    .clk       (clk),
    .en        (adv),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .contrast  (contrast),
    .expo_mean (expo_mean),
    .dsum      (dsum),
    .num       (num),
    .con       (con_f)
  );

  efw_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .dsum (dsum),
    .sat  (sat)
  );

  efw_div u_div (
    .clk     (clk),
    .en      (adv),
    .num     (num),
    .divisor (divisor),
    .g       (g)
  );

  efw_nlog u_nlog_sat (
    .clk (clk),
    .en  (adv),
    .u   ({1'b0, sat}),
    .nl  (nl_s)
  );

  efw_nlog u_nlog_con (
    .clk (clk),
    .en  (adv),
    .u   (con_d[efw_pkg::CON_DLY-1]),
    .nl  (nl_c)
  );

  efw_exp2 u_exp2_expo (
    .clk (clk),
    .en  (adv),
    .n   ({5'd0, g}),
    .res (expo_raw)
  );

  assign zero_in = ((saturation_exponent != 8'd0) && (sat == 15'd0)) ||
                   ((contrast_exponent != 8'd0) && (con_d[efw_pkg::CON_DLY-1] == 16'd0));

  // align the branches
  always_ff @(posedge clk) begin
    if (adv) begin
      con_d[0]  <= con_f;
      g_d[0]    <= g;
      zero_d[0] <= zero_in;
      expo_d[0] <= expo_raw;
      sat_d[0]  <= sat;
      for (int i = 1; i < efw_pkg::CON_DLY; i++) con_d[i] <= con_d[i-1];
      for (int i = 1; i < efw_pkg::G_DLY; i++) g_d[i] <= g_d[i-1];
      for (int i = 1; i < efw_pkg::ZERO_DLY; i++) zero_d[i] <= zero_d[i-1];
      for (int i = 1; i < efw_pkg::EXPO_DLY; i++) expo_d[i] <= expo_d[i-1];
      for (int i = 1; i < efw_pkg::SAT_DLY; i++) sat_d[i] <= sat_d[i-1];
    end
  end

  // weight exponent in the log2 domain
  always_ff @(posedge clk) begin
    if (adv) begin
      ps    <= {21'd0, saturation_exponent} * {8'd0, nl_s};
      pc    <= {21'd0, contrast_exponent} * {8'd0, nl_c};
      pg    <= {25'd0, exposure_exponent} * {8'd0, g_d[efw_pkg::G_DLY-1]};
      zero1 <= zero_d[efw_pkg::ZERO_DLY-1];
      n_w   <= zero1 ? '1 : total[33:4];
    end
  end

  assign total = {5'd0, ps} + {5'd0, pc} + {1'b0, pg} + 34'd8;

  efw_exp2 u_exp2_wgt (
    .clk (clk),
    .en  (adv),
    .n   (n_w),
    .res (wgt_raw)
  );

  assign res_new.weight      = (wgt_raw == 16'd0) ? 16'd1 : wgt_raw;
  assign res_new.saturation  = {1'b0, sat_d[efw_pkg::SAT_DLY-1]};
  assign res_new.exposedness = expo_d[efw_pkg::EXPO_DLY-1];

  // output buffer
  assign push = adv && vld[efw_pkg::PIPE_DEPTH-1];
  assign pop  = out_valid && out_ready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_next = cnt + 2'd1;
      2'b01:   cnt_next = cnt - 2'd1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ((cnt == 2'd0) || ((cnt == 2'd1) && pop))) begin
      buf0 <= res_new;
    end else if (pop) begin
      buf0 <= buf1;
    end
    if (push && (cnt == 2'd1) && !pop) begin
      buf1 <= res_new;
    end
  end

  assign out_valid   = (cnt != 2'd0);
  assign weight      = buf0.weight;
  assign saturation  = buf0.saturation;
  assign exposedness = buf0.exposedness;

endmodule

/* sim/efw_checker.sv */
// Result checker for the exposure-fusion weight block: predicts each pixel's weight, saturation and exposedness.
// Depends on efw_pkg; watches the input, output and configuration ports of the block.
module efw_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic [15:0] contrast,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] weight,
  input  logic [15:0] saturation,
  input  logic [15:0] exposedness,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]       mean_q, sigma_q, sat_exp, con_exp, expo_exp;
  efw_pkg::result_t expected_q[$];

  function automatic logic [63:0] root64(input logic [63:0] val);
    logic [63:0] v, r, b;
    v = val;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] neg_log2(input logic [15:0] u);
    int          p;
    logic [63:0] m, fr;
    p = 0;
    fr = 0;
    while (p < 15 && (u >> (p + 1)) != 0) p++;
    m = 64'(u) << (30 - p);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      fr = fr << 1;
      if (m >= (64'd2 << 30)) begin
        fr = fr | 1;
        m = m >> 1;
      end
    end
    return 64'(16 - p) * 65536 - fr;
  endfunction

  function automatic logic [15:0] pow2_neg(input logic [63:0] n);
    logic [63:0] q, h, r, c, res;
    q = n >> 16;
    h = 65536 - (n & 64'hFFFF);
    if (q > 40) return 0;
    if (h == 65536) begin
      r = 64'd2 << 30;
    end else begin
      r = 64'd1 << 30;
      c = root64(64'd2 << 60);
      for (int k = 1; k <= 16; k++) begin
        if ((h >> (16 - k)) & 1) r = (r * c) >> 30;
        c = root64(c << 30);
      end
    end
    res = (r + (64'd1 << (14 + q))) >> (15 + q);
    return res > 65535 ? 16'hFFFF : res[15:0];
  endfunction

  function automatic efw_pkg::result_t pixel_weight(input logic [7:0] r8, g8, b8,
                                                    input logic [15:0] con);
    logic [63:0]      ch[3];
    logic [63:0]      sum, dsum, d2sum, a, dv, am, sat, g, sig, total, w;
    logic             zero;
    efw_pkg::result_t res;
    ch[0] = 64'(r8); ch[1] = 64'(g8); ch[2] = 64'(b8);
    sum = ch[0] + ch[1] + ch[2];
    dsum = 0; d2sum = 0; total = 0; zero = 0;
    am = 255 * 64'(mean_q);
    for (int i = 0; i < 3; i++) begin
      a = 3 * ch[i];
      dv = a >= sum ? a - sum : sum - a;
      dsum += dv * dv;
      a = 256 * ch[i];
      dv = a >= am ? a - am : am - a;
      d2sum += dv * dv;
    end
    sat = root64((dsum << 32) / (27 * 65025));
    if (sat > 65535) sat = 65535;
    sig = sigma_q != 0 ? 64'(sigma_q) : 1;
    g = (d2sum * 94548) / (130050 * sig * sig);
    if (sat_exp != 0) begin
      if (sat == 0) zero = 1;
      else total += 64'(sat_exp) * neg_log2(sat[15:0]);
    end
    if (con_exp != 0) begin
      if (con == 0) zero = 1;
      else total += 64'(con_exp) * neg_log2(con);
    end
    total += 64'(expo_exp) * g;
    w = zero ? 0 : 64'(pow2_neg((total + 8) >> 4));
    res.weight = w < 1 ? 16'd1 : w[15:0];
    res.saturation = sat[15:0];
    res.exposedness = pow2_neg(g);
    return res;
  endfunction

  always @(posedge clk) begin
    efw_pkg::result_t want;
    if (rst) begin
      mean_q <= 128; sigma_q <= 51; sat_exp <= 16; con_exp <= 16; expo_exp <= 16;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (efw_pkg::cfg_reg_t'(cfg_index))
          efw_pkg::CFG_EXPO_MEAN:  mean_q <= cfg_data;
          efw_pkg::CFG_EXPO_SIGMA: sigma_q <= cfg_data;
          efw_pkg::CFG_SAT_EXP:    sat_exp <= cfg_data;
          efw_pkg::CFG_CON_EXP:    con_exp <= cfg_data;
          efw_pkg::CFG_EXPO_EXP:   expo_exp <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_q.insert(expected_q.size(), pixel_weight(red, green, blue, contrast));
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected beat: weight %0d", weight);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.weight !== weight || want.saturation !== saturation ||
              want.exposedness !== exposedness) begin
            if (want.weight !== weight)
              $error("weight expected %0d actual %0d", want.weight, weight);
            if (want.saturation !== saturation)
              $error("saturation expected %0d actual %0d", want.saturation, saturation);
            if (want.exposedness !== exposedness)
              $error("exposedness expected %0d actual %0d", want.exposedness, exposedness);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_q.size();
  end
endmodule

/* sim/tb_top.sv */
// Testbench top for exposure_fusion_pixel_weight_top: stimulus, configuration, verdict.
// Depends on efw_pkg, the block RTL and efw_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, out_ready = 0, cfg_wr_en = 0;
  logic        in_ready, out_valid;
  logic [7:0]  red = 0, green = 0, blue = 0, cfg_data = 0;
  logic [15:0] contrast = 0, weight, saturation, exposedness;
  logic [2:0]  cfg_index = 0;
  int          fail_count, pending;
  bit          long_hold = 0, sending = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  exposure_fusion_pixel_weight_top dut (.*);
  efw_checker chk (.*);

  // called at a falling edge; leaves valid high after the beat, drain drops it
  task automatic send_pixel(input logic [7:0] r, g, b, input logic [15:0] c);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    red <= r; green <= g; blue <= b; contrast <= c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input efw_pkg::cfg_reg_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_wr_en <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic random_pixels(input int n);
    logic [7:0]  base;
    logic [15:0] c;
    for (int i = 0; i < n; i++) begin
      base = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 5))
        0: c = 0;
        1: c = 16'hFFFF;
        default: c = 16'($urandom_range(0, 65535));
      endcase
      if ($urandom_range(0, 4) == 0)
        send_pixel(base, base, base, c);
      else
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), c);
    end
  endtask

  // receiver
  initial begin
    int stall;
    @(negedge clk);
    while (1) begin
      if (long_hold) begin
        out_ready <= 0;
        repeat (200) @(negedge clk);
        long_hold = 0;
      end
      stall = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        out_ready <= 0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1;
      @(negedge clk);
    end
  end

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: extremes, gray, zero contrast, full weight
    send_pixel(0, 0, 0, 0);
    send_pixel(255, 255, 255, 16'hFFFF);
    send_pixel(255, 0, 0, 16'hFFFF);
    send_pixel(0, 255, 0, 1);
    send_pixel(0, 0, 255, 16'h8000);
    send_pixel(128, 128, 128, 16'hFFFF);
    send_pixel(255, 0, 255, 0);
    send_pixel(170, 85, 0, 16'h5555);
    drain();
    write_reg(efw_pkg::CFG_SAT_EXP, 0);
    write_reg(efw_pkg::CFG_CON_EXP, 0);
    write_reg(efw_pkg::CFG_EXPO_EXP, 0);
    send_pixel(128, 128, 128, 0);
    send_pixel(0, 0, 0, 0);
    drain();
    write_reg(efw_pkg::CFG_EXPO_EXP, 16);
    send_pixel(128, 128, 128, 0);
    drain();
    write_reg(efw_pkg::CFG_EXPO_SIGMA, 0);
    write_reg(efw_pkg::CFG_EXPO_MEAN, 255);
    write_reg(efw_pkg::CFG_SAT_EXP, 255);
    write_reg(efw_pkg::CFG_CON_EXP, 255);
    write_reg(efw_pkg::CFG_EXPO_EXP, 255);
    write_reg(efw_pkg::cfg_reg_t'(3'd7), 8'h55);
    send_pixel(255, 255, 254, 16'hFFFF);
    send_pixel(255, 200, 100, 16'hFFFE);
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(efw_pkg::CFG_EXPO_MEAN, phase == 0 ? 8'd0 : 8'($urandom_range(0, 255)));
      write_reg(efw_pkg::CFG_EXPO_SIGMA, phase == 1 ? 8'd255 : 8'($urandom_range(1, 255)));
      write_reg(efw_pkg::CFG_SAT_EXP, phase == 2 ? 8'd0 : 8'($urandom_range(0, 255)));
      write_reg(efw_pkg::CFG_CON_EXP, phase == 3 ? 8'd255 : 8'($urandom_range(0, 64)));
      write_reg(efw_pkg::CFG_EXPO_EXP, 8'($urandom_range(0, 48)));
      if (phase == 2) long_hold = 1;
      random_pixels(210);
      drain();
    end
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
